/* design/scrambled_parameter_frame_codec_defines.svh */
// Assertion macros for the scrambled parameter frame codec.
`ifndef SCRAMBLED_PARAMETER_FRAME_CODEC_DEFINES_SVH
`define SCRAMBLED_PARAMETER_FRAME_CODEC_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCPF_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("scpf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCPF_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("scpf: next-cycle check failed");

`endif

/* design/scpf_pkg.sv */
// Types and constants shared by the scrambled parameter frame codec.
`timescale 1ns / 1ps
package scpf_pkg;

  localparam int FRAME_BYTES = 7;
  localparam int RX_CNT_W    = 3;
  localparam logic [RX_CNT_W-1:0] RX_LAST = RX_CNT_W'(FRAME_BYTES - 1);

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_RX    = 2'd1,
    FUNC_KEY   = 2'd2
  } func_e;

  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_RX = 1'b1;

  // Padding for unused leading value bytes
  localparam logic [7:0] PAD3 = 8'h69;
  localparam logic [7:0] PAD4 = 8'h96;
  localparam logic [7:0] PAD5 = 8'h99;

  // Length markers of a descrambled byte 1
  localparam logic [7:0] MARK_1B = 8'h55;
  localparam logic [7:0] MARK_2B = 8'h5A;
  localparam logic [7:0] MARK_3B = 8'hA5;
  localparam logic [7:0] MARK_4B = 8'hAA;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  frame_id;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;
    logic [7:0]  key_byte;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] read_value;
    logic        frame_ok;
  } out_t;

  // One unit of work for the back end: a whole scrambled frame or a decode result
  typedef struct packed {
    logic                        is_rx;
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [31:0]                 value;
    logic                        ok;
  } job_t;

endpackage

/* design/scpf_front.sv */
// Front end: classifies items, keeps key and receive state, builds frame jobs.
`timescale 1ns / 1ps
module scpf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  scpf_pkg::in_t in_i,
  output logic          job_valid_o,
  output scpf_pkg::job_t job_o
);
  import scpf_pkg::*;

  logic [7:0]          key_q, key_d;
  logic [RX_CNT_W-1:0] rx_count_q, rx_count_d;
  logic [7:0]          store_q [FRAME_BYTES-1];

  function automatic logic [7:0] permute_key(input logic [7:0] k);
    permute_key = {k[2], k[4], k[0], k[6], k[1], k[7], k[3], k[5]};
  endfunction

  // Encode path
  logic [FRAME_BYTES-1:0][7:0] tx_plain, tx_frame;
  logic [1:0]                  tx_len;

  always_comb begin
    tx_plain    = '0;
    tx_plain[3] = PAD3;
    tx_plain[4] = PAD4;
    tx_plain[5] = PAD5;
    tx_plain[6] = in_i.write_value[7:0];
    if (in_i.write_value[31:24] != 8'd0) begin
      tx_len      = 2'd3;
      tx_plain[3] = in_i.write_value[31:24];
      tx_plain[4] = in_i.write_value[23:16];
      tx_plain[5] = in_i.write_value[15:8];
    end else if (in_i.write_value[23:16] != 8'd0) begin
      tx_len      = 2'd2;
      tx_plain[4] = in_i.write_value[23:16];
      tx_plain[5] = in_i.write_value[15:8];
    end else if (in_i.write_value[15:8] != 8'd0) begin
      tx_len      = 2'd1;
      tx_plain[5] = in_i.write_value[15:8];
    end else begin
      tx_len      = 2'd0;
    end
    tx_plain[1] = {in_i.frame_id, tx_len};
    tx_frame[0] = permute_key(key_q);
    tx_frame[1] = tx_plain[1] ^ key_q;
    tx_frame[3] = tx_plain[3] ^ key_q;
    tx_frame[4] = tx_plain[4] ^ key_q;
    tx_frame[5] = tx_plain[5] ^ key_q;
    tx_frame[6] = tx_plain[6] ^ key_q;
    tx_frame[2] = tx_frame[0] + tx_frame[1] + tx_frame[3] + tx_frame[4]
                + tx_frame[5] + tx_frame[6];
  end

  // Decode path, used on the final byte of a received frame
  logic [7:0]  rx_key, rx_sum;
  logic [FRAME_BYTES-1:0][7:0] rx_plain;
  logic [31:0] rx_value;
  logic        rx_known;

  always_comb begin
    rx_key      = ~store_q[0];
    rx_plain[0] = rx_key;
    rx_plain[1] = store_q[1] ^ rx_key;
    rx_plain[2] = store_q[2] ^ rx_key;
    rx_plain[3] = store_q[3] ^ rx_key;
    rx_plain[4] = store_q[4] ^ rx_key;
    rx_plain[5] = store_q[5] ^ rx_key;
    rx_plain[6] = in_i.rx_byte ^ rx_key;
    rx_known    = 1'b1;
    case (rx_plain[1])
      MARK_1B: rx_value = {24'd0, rx_plain[6]};
      MARK_2B: rx_value = {16'd0, rx_plain[5], rx_plain[6]};
      MARK_3B: rx_value = {8'd0, rx_plain[4], rx_plain[5], rx_plain[6]};
      MARK_4B: rx_value = {rx_plain[3], rx_plain[4], rx_plain[5], rx_plain[6]};
      default: begin
        rx_value = '0;
        rx_known = 1'b0;
      end
    endcase
    rx_sum = rx_plain[0] + rx_plain[1] + rx_plain[3] + rx_plain[4]
           + rx_plain[5] + rx_plain[6];
  end

  always_comb begin
    key_d       = key_q;
    rx_count_d  = rx_count_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    if (accept_i) begin
      case (in_i.func)
        FUNC_WRITE: begin
          job_valid_o = 1'b1;
          job_o.is_rx = KIND_TX;
          job_o.bytes = tx_frame;
        end
        FUNC_RX: begin
          if (rx_count_q == RX_LAST) begin
            rx_count_d  = '0;
            key_d       = rx_key;
            job_valid_o = 1'b1;
            job_o.is_rx = KIND_RX;
            job_o.value = rx_value;
            job_o.ok    = rx_known && (rx_sum == rx_plain[2]);
          end else begin
            rx_count_d = rx_count_q + RX_CNT_W'(1);
          end
        end
        FUNC_KEY: key_d = in_i.key_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= '0;
      rx_count_q <= '0;
    end else begin
      key_q      <= key_d;
      rx_count_q <= rx_count_d;
    end
  end

  // Hold received bytes 0..5 until the frame completes
  always_ff @(posedge clk_i) begin
    if (accept_i && in_i.func == FUNC_RX && rx_count_q != RX_LAST) begin
      store_q[rx_count_q] <= in_i.rx_byte;
    end
  end

endmodule

/* design/scpf_queue.sv */
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
module scpf_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  input  scpf_pkg::job_t  wr_job_i,
  input  logic            rd_pop_i,
  output logic            rd_valid_o,
  output scpf_pkg::job_t  rd_job_o,
  output logic            full_o
);
  import scpf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_wr, do_rd;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full_o     = (count_q == CW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_job_o   = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_rd) rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_wr && !do_rd) begin
        count_q <= count_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

/* design/scpf_back.sv */
// Back end: serialises frame jobs into results and holds the output register.
`timescale 1ns / 1ps
module scpf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  scpf_pkg::job_t  job_i,
  output logic            job_pop_o,
  input  logic            pop,
  output logic            empty,
  output scpf_pkg::out_t  out_o
);
  import scpf_pkg::*;

  logic [RX_CNT_W-1:0] idx_q;
  logic                out_valid_q;
  out_t                out_q, res;
  logic                load, res_last;

  assign empty    = !out_valid_q;
  assign out_o    = out_q;
  assign load     = job_valid_i && (!out_valid_q || pop);
  assign res_last = job_i.is_rx || (idx_q == RX_LAST);
  assign job_pop_o = load && res_last;

  always_comb begin
    res.kind       = job_i.is_rx;
    res.last       = res_last;
    res.data_byte  = job_i.is_rx ? 8'd0 : job_i.bytes[idx_q];
    res.read_value = job_i.is_rx ? job_i.value : 32'd0;
    res.frame_ok   = job_i.is_rx && job_i.ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        // advance through the frame, rewind at its end
        idx_q       <= res_last ? '0 : idx_q + RX_CNT_W'(1);
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

endmodule

/* design/scrambled_parameter_frame_codec.sv */
// Top level of the scrambled parameter frame codec.
// Input channel: push/full with in_i (func, frame_id, write_value, rx_byte,
// key_byte); an item transfers when push is high and full is low.
// Result channel: empty/pop with out_o (kind, data_byte, last, read_value,
// frame_ok); the oldest result shows while empty is low and transfers on pop.
// A write item yields seven scrambled frame bytes, one per cycle while pop is
// high, the last flagged by last. A received byte yields nothing until the
// seventh byte of a frame, which yields one decoded result. A key load yields
// nothing. The first result of an item is registered in the job queue and then
// in the output register. Throughput: one item per cycle into the job queue
// while it is not full; the back-end serialiser emits one result per cycle
// while pop is high. Items that give no result never wait on the back end
// unless the queue is full. Reset clears the key, the receive byte count, the
// queue and the output register. A stalled receiver holds the output register;
// the queue then fills and full rises, while earlier results wait in order.
`timescale 1ns / 1ps
module scrambled_parameter_frame_codec #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  scpf_pkg::in_t  in_i,
  output logic           empty,
  input  logic           pop,
  output scpf_pkg::out_t out_o
);
  import scpf_pkg::*;
  `include "scrambled_parameter_frame_codec_defines.svh"

  logic accept, job_valid, head_valid, head_pop;
  job_t job, head_job;

  assign accept = push && !full;

  scpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  scpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (job_valid),
    .wr_job_i   (job),
    .rd_pop_i   (head_pop),
    .rd_valid_o (head_valid),
    .rd_job_o   (head_job),
    .full_o     (full)
  );

  scpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (head_pop),
    .pop         (pop),
    .empty       (empty),
    .out_o       (out_o)
  );

  // A frame byte that is not the last is always followed by the next one
  `SCPF_ASSERT_NEXT(a_frame_unbroken, clk_i, rst_ni,
    pop && !empty && out_o.kind == KIND_TX && !out_o.last, !empty)
  // Decoded results stand alone and carry no frame byte
  `SCPF_ASSERT_NOW(a_rx_result_shape, clk_i, rst_ni,
    !empty && out_o.kind == KIND_RX, out_o.last && out_o.data_byte == 8'd0)
  // The queue only fills after an item was taken in
  `SCPF_ASSERT_NOW(a_full_after_transfer, clk_i, rst_ni,
    $rose(full), $past(push && !full))

endmodule
